// ===== hdl/hsfd_pkg.sv =====
`timescale 1ns / 1ps

package hsfd_pkg;

   // Byte position within the six-byte measurement frame
   typedef logic [2:0] hsfd_pos_type;

   localparam hsfd_pos_type POS_T_MSB = 3'd0;
   localparam hsfd_pos_type POS_T_LSB = 3'd1;
   localparam hsfd_pos_type POS_T_CRC = 3'd2;
   localparam hsfd_pos_type POS_H_MSB = 3'd3;
   localparam hsfd_pos_type POS_H_LSB = 3'd4;
   localparam hsfd_pos_type POS_H_CRC = 3'd5;

   // CRC-8, polynomial x^8 + x^5 + x^4 + 1, no reflection, no final xor
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Conversion spans and offsets, in hundredths
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [13:0] HUM_SPAN    = 14'd12500;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [14:0] HUM_OFFSET  = 15'd600;
   localparam logic [14:0] HUM_MAX     = 15'd10000;

   // Check status codes
   localparam logic [1:0] STATUS_OK = 2'd0;

   // One byte through the CRC register, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(x / 65535) for x below 2^31: (x + (x >> 16) + 1) >> 16
   function automatic logic [14:0] div_65535(input logic [30:0] x);
      logic [31:0] s;
      s = {1'b0, x} + {17'd0, x[30:16]} + 32'd1;
      return s[30:16];
   endfunction

endpackage

// ===== hdl/hsfd_if.sv =====
`timescale 1ns / 1ps

// Request channel: one frame byte per request
interface hsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Response channel: one converted measurement per frame
interface hsfd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] temperature_centi;
   logic        [13:0] humidity_centi;
   logic               frame_ok;
   logic        [1:0]  check_status;

   modport source (output valid, output temperature_centi, output humidity_centi,
                   output frame_ok, output check_status, input ready);
   modport sink   (input valid, input temperature_centi, input humidity_centi,
                   input frame_ok, input check_status, output ready);
endinterface

// ===== hdl/humidity_sensor_frame_decoder.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Payload                                          Role
// req_chan   in         rx_byte[7:0], frame_start                        frame bytes
// rsp_chan   out        temperature_centi[14:0] s, humidity_centi[13:0], measurement
//                       frame_ok, check_status[1:0]
//
// One request is taken every cycle while the response is not stalled; the sixth
// byte of a frame yields a response through the product register, then the output register.
// The CRC update and the byte position advance complete in the accepting cycle.
// Synchronous reset clears position, CRC, raw words and all valid flags.
// A stalled response holds the whole pipe and deasserts req_chan.ready.

module humidity_sensor_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   hsfd_req_if.sink    req_chan,
   hsfd_rsp_if.source  rsp_chan
);
   import hsfd_pkg::*;

   // Frame state
   hsfd_pos_type pos_ff, pos_in;
   logic [7:0]   crc_ff, crc_in;
   logic [15:0]  temp_raw_ff, temp_raw_in;
   logic [15:0]  hum_raw_ff, hum_raw_in;
   logic         temp_bad_ff, temp_bad_in;

   // Product stage
   logic         prod_valid_ff, prod_valid_in;
   logic [30:0]  temp_prod_ff, temp_prod_in;
   logic [29:0]  hum_prod_ff, hum_prod_in;
   logic [1:0]   prod_status_ff, prod_status_in;

   // Output register
   logic         out_valid_ff;
   logic [14:0]  out_temp_ff, out_temp_in;
   logic [13:0]  out_hum_ff, out_hum_in;
   logic [1:0]   out_status_ff;

   logic         advance;
   logic         accept;
   hsfd_pos_type pos;
   logic         last_byte;
   logic [14:0]  temp_q;
   logic [14:0]  hum_q;
   logic [15:0]  temp_signed;
   logic [14:0]  hum_diff;

   // Whole pipe moves unless the response is stalled
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   // Byte position, CRC and raw word capture
   always_comb begin
      pos         = req_chan.frame_start ? POS_T_MSB : pos_ff;
      if (pos inside {3'd6, 3'd7}) begin
         pos = POS_T_MSB;
      end
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      hum_raw_in  = hum_raw_ff;
      temp_bad_in = temp_bad_ff;
      last_byte   = 1'b0;
      case (pos)
         POS_T_MSB: begin
            crc_in      = crc8_update(CRC_INIT, req_chan.rx_byte);
            temp_raw_in = {req_chan.rx_byte, 8'h00};
         end
         POS_T_LSB: begin
            crc_in      = crc8_update(crc_ff, req_chan.rx_byte);
            temp_raw_in = {temp_raw_ff[15:8], req_chan.rx_byte};
         end
         POS_T_CRC: begin
            temp_bad_in = (crc_ff != req_chan.rx_byte);
            crc_in      = CRC_INIT;
         end
         POS_H_MSB: begin
            crc_in     = crc8_update(CRC_INIT, req_chan.rx_byte);
            hum_raw_in = {req_chan.rx_byte, 8'h00};
         end
         POS_H_LSB: begin
            crc_in     = crc8_update(crc_ff, req_chan.rx_byte);
            hum_raw_in = {hum_raw_ff[15:8], req_chan.rx_byte};
         end
         POS_H_CRC: begin
            crc_in    = CRC_INIT;
            last_byte = 1'b1;
         end
         default: begin
            crc_in = CRC_INIT;
         end
      endcase
      pos_in = last_byte ? POS_T_MSB : pos + 3'd1;
   end

   // Scaling products and CRC status, launched on the last byte
   always_comb begin
      prod_valid_in  = accept && last_byte;
      temp_prod_in   = 31'(TEMP_SPAN) * 31'(temp_raw_ff);
      hum_prod_in    = 30'(HUM_SPAN) * 30'(hum_raw_ff);
      prod_status_in = {(crc_ff != req_chan.rx_byte), temp_bad_ff};
   end

   // Division by 65535, offsets and humidity clamp
   always_comb begin
      temp_q      = div_65535(temp_prod_ff);
      hum_q       = div_65535({1'b0, hum_prod_ff});
      temp_signed = {1'b0, temp_q} - TEMP_OFFSET;
      out_temp_in = temp_signed[14:0];
      hum_diff    = hum_q - HUM_OFFSET;
      if (hum_q < HUM_OFFSET) begin
         out_hum_in = 14'd0;
      end else if (hum_diff > HUM_MAX) begin
         out_hum_in = HUM_MAX[13:0];
      end else begin
         out_hum_in = hum_diff[13:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_T_MSB;
         crc_ff        <= CRC_INIT;
         temp_raw_ff   <= 16'd0;
         hum_raw_ff    <= 16'd0;
         temp_bad_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff      <= pos_in;
            crc_ff      <= crc_in;
            temp_raw_ff <= temp_raw_in;
            hum_raw_ff  <= hum_raw_in;
            temp_bad_ff <= temp_bad_in;
         end
         if (advance) begin
            prod_valid_ff <= prod_valid_in;
            out_valid_ff  <= prod_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         temp_prod_ff   <= temp_prod_in;
         hum_prod_ff    <= hum_prod_in;
         prod_status_ff <= prod_status_in;
         out_temp_ff    <= out_temp_in;
         out_hum_ff     <= out_hum_in;
         out_status_ff  <= prod_status_ff;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.temperature_centi = signed'(out_temp_ff);
   assign rsp_chan.humidity_centi    = out_hum_ff;
   assign rsp_chan.check_status      = out_status_ff;
   assign rsp_chan.frame_ok          = (out_status_ff == STATUS_OK);

endmodule

// ===== hdl/hsfd_checker.sv =====
`timescale 1ns / 1ps

module hsfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [14:0] temperature_centi,
   input logic        [13:0] humidity_centi,
   input logic               frame_ok,
   input logic        [1:0]  check_status
);
   import hsfd_pkg::*;

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(temperature_centi)
         && $stable(humidity_centi) && $stable(check_status))
      else $error("stalled response changed");

   // Back-pressure reaches the request side
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // Humidity is clamped
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> humidity_centi <= 14'd10000)
      else $error("humidity out of range");

   // Temperature stays within the sensor span
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000)
      else $error("temperature out of range");

   // Overall flag agrees with the status code
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> frame_ok == (check_status == STATUS_OK))
      else $error("frame_ok disagrees with check_status");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .temperature_centi (rsp_chan.temperature_centi),
   .humidity_centi    (rsp_chan.humidity_centi),
   .frame_ok          (rsp_chan.frame_ok),
   .check_status      (rsp_chan.check_status)
);

// ===== tb/humidity_sensor_frame_decoder_tb.sv =====
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_tb;

   // Watchdog limit, drain time and stimulus sizes
   localparam int STALL_LIMIT   = 3000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int BYTES_TARGET  = 520;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int REPORT_LIMIT  = 40;
   localparam int FULL_SCALE    = 65535;
   localparam int TEMP_SPAN_C   = 17500;
   localparam int TEMP_BASE_C   = -4500;
   localparam int HUM_SPAN_C    = 12500;
   localparam int HUM_BASE_C    = -600;
   localparam int HUM_CEIL_C    = 10000;

   // One converted measurement as the block should give it
   typedef struct {
      logic signed [14:0] temperature_centi;
      logic        [13:0] humidity_centi;
      logic               frame_ok;
      logic        [1:0]  check_status;
   } measurement_type;

   logic clock = 1'b0;
   logic reset;

   hsfd_req_if req_chan ();
   hsfd_rsp_if rsp_chan ();

   humidity_sensor_frame_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   measurement_type pending_measurements[$];

   // Decoder state mirrored by the predictor
   hsfd_pkg::hsfd_pos_type frame_pos;
   logic [7:0]  frame_crc;
   logic [15:0] temp_word;
   logic [15:0] hum_word;
   logic        temp_word_bad;

   int mismatches      = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int faulty_frames   = 0;
   int clamped_frames  = 0;
   int burst_left      = 0;
   bit sender_steady   = 1'b0;
   int hold_off_left   = 0;

   // Bitwise CRC-8, data shifted in MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ data[i];
         c  = {c[6:0], 1'b0} ^ (fb ? hsfd_pkg::CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   function automatic logic [7:0] word_crc(input logic [15:0] w);
      return crc8_step(crc8_step(hsfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   // Scale both raw words and queue the measurement
   task automatic queue_measurement(input logic hum_bad);
      measurement_type m;
      longint          q;
      int              h;
      q = (longint'(TEMP_SPAN_C) * temp_word) / FULL_SCALE;
      m.temperature_centi = 15'(int'(q) + TEMP_BASE_C);
      q = (longint'(HUM_SPAN_C) * hum_word) / FULL_SCALE;
      h = int'(q) + HUM_BASE_C;
      if (h < 0 || h > HUM_CEIL_C) begin
         clamped_frames++;
      end
      if (h < 0) begin
         h = 0;
      end
      if (h > HUM_CEIL_C) begin
         h = HUM_CEIL_C;
      end
      m.humidity_centi = 14'(h);
      m.check_status   = {hum_bad, temp_word_bad};
      m.frame_ok       = (m.check_status == hsfd_pkg::STATUS_OK);
      if (!m.frame_ok) begin
         faulty_frames++;
      end
      pending_measurements.push_back(m);
   endtask

   // Advance the predicted decoder by one accepted byte
   task automatic decode_byte(input logic [7:0] b, input logic start);
      hsfd_pkg::hsfd_pos_type pos;
      if (start) begin
         frame_pos = hsfd_pkg::POS_T_MSB;
         frame_crc = hsfd_pkg::CRC_INIT;
      end
      pos = frame_pos;
      if (pos > hsfd_pkg::POS_H_CRC) begin
         pos       = hsfd_pkg::POS_T_MSB;
         frame_crc = hsfd_pkg::CRC_INIT;
      end
      case (pos)
         hsfd_pkg::POS_T_MSB: begin
            frame_crc = crc8_step(hsfd_pkg::CRC_INIT, b);
            temp_word = {b, 8'h00};
         end
         hsfd_pkg::POS_T_LSB: begin
            frame_crc      = crc8_step(frame_crc, b);
            temp_word[7:0] = b;
         end
         hsfd_pkg::POS_T_CRC: begin
            temp_word_bad = (frame_crc != b);
            frame_crc     = hsfd_pkg::CRC_INIT;
         end
         hsfd_pkg::POS_H_MSB: begin
            frame_crc = crc8_step(hsfd_pkg::CRC_INIT, b);
            hum_word  = {b, 8'h00};
         end
         hsfd_pkg::POS_H_LSB: begin
            frame_crc     = crc8_step(frame_crc, b);
            hum_word[7:0] = b;
         end
         default: begin
         end
      endcase
      if (pos == hsfd_pkg::POS_H_CRC) begin
         queue_measurement(frame_crc != b);
         frame_pos = hsfd_pkg::POS_T_MSB;
         frame_crc = hsfd_pkg::CRC_INIT;
      end else begin
         frame_pos = pos + 3'd1;
      end
   endtask

   // Offer one request, in bursts with random gaps, and wait for the handshake
   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      if (!sender_steady && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_chan.valid       <= 1'b1;
      req_chan.rx_byte     <= b;
      req_chan.frame_start <= start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      decode_byte(b, start);
      bytes_sent++;
   endtask

   // First count bytes of a frame; CRC bytes xored with the given fault masks
   task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                             input logic start, input logic [7:0] t_fault,
                             input logic [7:0] h_fault, input int count);
      logic [7:0] frame [6];
      frame[0] = t_raw[15:8];
      frame[1] = t_raw[7:0];
      frame[2] = word_crc(t_raw) ^ t_fault;
      frame[3] = h_raw[15:8];
      frame[4] = h_raw[7:0];
      frame[5] = word_crc(h_raw) ^ h_fault;
      for (int i = 0; i < count; i++) begin
         send_byte(frame[i], (i == 0) ? start : 1'b0);
      end
   endtask

   // Raw words weighted towards the ends of the scale and the clamp points
   function automatic logic [15:0] pick_raw(input bit humidity);
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return humidity ? 16'($urandom_range(3100, 3200)) : 16'($urandom_range(0, 300));
         3: return humidity ? 16'($urandom_range(55500, 55650))
                            : 16'($urandom_range(65200, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      end
   endtask

   // Scale extremes, both humidity clamps, wrap without a start flag
   task automatic test_extremes();
      send_frame(16'h0000, 16'h0000, 1'b1, 8'h00, 8'h00, 6);
      send_frame(16'hFFFF, 16'hFFFF, 1'b0, 8'h5A, 8'h00, 6);
   endtask

   // Start flag mid-frame drops the partial frame
   task automatic test_resync();
      send_frame(16'h1234, 16'h8000, 1'b1, 8'h00, 8'h00, 2);
      send_frame(16'h6666, 16'h9999, 1'b1, 8'h00, 8'h01, 6);
   endtask

   // Both checksums wrong; values still converted
   task automatic test_crc_faults();
      send_frame(16'hBEEF, 16'h4000, 1'b1, 8'h80, 8'hFF, 6);
   endtask

   // Mostly well-formed frames, some faulty, truncated or plain noise
   task automatic test_random_frames();
      int         kind;
      int         n;
      int         sel;
      bit         resync_due;
      logic [7:0] t_fault;
      logic [7:0] h_fault;
      resync_due = 1'b0;
      while (bytes_sent < BYTES_TARGET) begin
         kind = $urandom_range(0, 19);
         if (kind < 14) begin
            send_frame(pick_raw(1'b0), pick_raw(1'b1),
                       resync_due || ($urandom_range(0, 3) != 0), 8'h00, 8'h00, 6);
            resync_due = 1'b0;
         end else if (kind < 17) begin
            sel     = $urandom_range(1, 3);
            t_fault = sel[0] ? 8'($urandom_range(1, 255)) : 8'h00;
            h_fault = sel[1] ? 8'($urandom_range(1, 255)) : 8'h00;
            send_frame(pick_raw(1'b0), pick_raw(1'b1), 1'b1, t_fault, h_fault, 6);
            resync_due = 1'b0;
         end else if (kind < 19) begin
            n = $urandom_range(1, 5);
            send_frame(16'($urandom), 16'($urandom), 1'b1, 8'h00, 8'h00, n);
            resync_due = 1'b1;
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               send_byte(8'($urandom), 1'($urandom));
            end
            resync_due = 1'b1;
         end
      end
   endtask

   // Long receiver hold-off while frames keep coming back to back
   task automatic test_backpressure();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      hold_off_left = HOLD_OFF_LEN;
      sender_steady = 1'b1;
      @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         send_frame(pick_raw(1'b0), pick_raw(1'b1), 1'b1, 8'h00, 8'h00, 6);
      end
      sender_steady = 1'b0;
   endtask

   // Receiver: rotating stall pattern, replaced now and then, plus hold-off
   initial begin : receiver
      logic [7:0] stall_pattern;
      int         pattern_age;
      stall_pattern = 8'hFF;
      pattern_age   = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_pattern = 8'hFF;
                  1: stall_pattern = 8'hAA;
                  default: stall_pattern = 8'($urandom) | 8'h01;
               endcase
               pattern_age = $urandom_range(40, 120);
            end
            pattern_age--;
            stall_pattern  = {stall_pattern[0], stall_pattern[7:1]};
            rsp_chan.ready <= stall_pattern[0];
         end
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : result_check
      measurement_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_measurements.size() == 0) begin
            report_mismatch("response with nothing pending", 1, 0);
         end else begin
            want = pending_measurements.pop_front();
            results_checked++;
            if (rsp_chan.temperature_centi !== want.temperature_centi) begin
               report_mismatch("temperature_centi", int'(rsp_chan.temperature_centi),
                               int'(want.temperature_centi));
            end
            if (rsp_chan.humidity_centi !== want.humidity_centi) begin
               report_mismatch("humidity_centi", int'(rsp_chan.humidity_centi),
                               int'(want.humidity_centi));
            end
            if (rsp_chan.frame_ok !== want.frame_ok) begin
               report_mismatch("frame_ok", int'(rsp_chan.frame_ok), int'(want.frame_ok));
            end
            if (rsp_chan.check_status !== want.check_status) begin
               report_mismatch("check_status", int'(rsp_chan.check_status),
                               int'(want.check_status));
            end
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_measurements.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.rx_byte     <= 8'h00;
      req_chan.frame_start <= 1'b0;
      frame_pos     = hsfd_pkg::POS_T_MSB;
      frame_crc     = hsfd_pkg::CRC_INIT;
      temp_word     = '0;
      hum_word      = '0;
      temp_word_bad = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_resync();
      test_crc_faults();
      test_random_frames();
      test_backpressure();

      // Drain: all predictions met, then room for stray responses
      req_chan.valid <= 1'b0;
      while (pending_measurements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d frame bytes, checked %0d measurements", bytes_sent, results_checked);
      $display("  of which %0d with checksum faults and %0d with clamped humidity",
               faulty_frames, clamped_frames);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/hsfd_pkg.sv
hdl/hsfd_if.sv
hdl/humidity_sensor_frame_decoder.sv
hdl/hsfd_checker.sv
tb/humidity_sensor_frame_decoder_tb.sv
